// File: sv/dtrt_pkg.sv
// package for the dirty tile rectangle tracker
// shared types, constants and controller/datapath command structs; no dependencies
`default_nettype none
package dtrt_pkg;
   localparam int GRID_COLS = 8;
   localparam int GRID_ROWS = 8;
   localparam int COL_W = $clog2(GRID_COLS + 1);
   localparam int ROW_W = $clog2(GRID_ROWS + 1);
   localparam int MAX_RESULTS = 64;
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] REG_FRAME_W = 3'd0;
   localparam logic [2:0] REG_FRAME_H = 3'd1;
   localparam logic [2:0] REG_TILE_W = 3'd2;
   localparam logic [2:0] REG_TILE_H = 3'd3;
   localparam logic [2:0] REG_WIDEN = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRID,
      ST_ADD_CLIP,
      ST_ADD_DIV,
      ST_ADD_MARK,
      ST_GET_SCAN,
      ST_GET_RUN,
      ST_GET_DOWN,
      ST_GET_EMIT,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture input item
      logic grid_start; // start grid size division
      logic clip;       // clip and widen add rectangle
      logic div_start;  // start tile index division
      logic mark_row;   // mark one row of the add
      logic map_clear;  // clear dirty map
      logic scan_next;  // advance scan cursor
      logic run_step;   // extend span right by one
      logic down_step;  // extend depth down by one row
      logic emit_calc;  // compute pixel rectangle, clear tiles
      logic ack;        // load acknowledgement result
      logic load_rect;  // load rectangle result
      logic load_none;  // load not-found result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic grid_done;
      logic add_empty;
      logic div_done;
      logic mark_last;
      logic scan_dirty;
      logic scan_end;
      logic run_more;
      logic down_ok;
      logic rect_ok;
      logic limit;
      logic any_out;
   } status_type;
endpackage
`default_nettype wire

// File: sv/dtrt_divider.sv
// restoring divider, one quotient bit per cycle
// depends on nothing but its ports; used for grid size and tile index
`default_nettype none
module dtrt_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [13:0] dividend,
   input  wire logic [10:0] divisor,
   output logic             done,
   output logic [13:0]      quotient
);
   logic [13:0] q_ff, q_in;
   logic [13:0] r_ff, r_in;
   logic [10:0] d_ff, d_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [14:0] trial;

   // shift-subtract step
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[13]} - {4'd0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[14]) begin
            r_in = trial[13:0];
            q_in = {q_ff[12:0], 1'b1};
         end else begin
            r_in = {r_ff[12:0], q_ff[13]};
            q_in = {q_ff[12:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd13) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   // final quotient bit formed by this step, valid in the done cycle
   assign done = busy_ff && (cnt_ff == 4'd13);
   assign quotient = {q_ff[12:0], ~trial[14]};
endmodule
`default_nettype wire

// File: sv/dtrt_ctrl.sv
// controller state machine for the dirty tile tracker
// depends on dtrt_pkg; drives datapath commands from status
`default_nettype none
module dtrt_ctrl
   import dtrt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic       out_busy,
   input  wire logic       out_take,
   input  status_type      status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] sub_ff, sub_in;

   assign req_ready = (state_ff == ST_IDLE) && !out_busy;

   // next state
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      sub_in = sub_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_op;
               sub_in = 2'd0;
               if (req_op == OP_ADD || req_op == OP_GET) state_in = ST_GRID;
               else state_in = ST_OUT;
            end
         end
         ST_GRID: begin
            // two grid divisions: columns then rows
            if (status.grid_done) begin
               if (sub_ff == 2'd1) begin
                  sub_in = 2'd0;
                  state_in = (op_ff == OP_ADD) ? ST_ADD_CLIP : ST_GET_SCAN;
               end else sub_in = 2'd1;
            end
         end
         ST_ADD_CLIP: state_in = status.add_empty ? ST_OUT : ST_ADD_DIV;
         ST_ADD_DIV: begin
            // four index divisions
            if (status.div_done) begin
               if (sub_ff == 2'd3) state_in = ST_ADD_MARK;
               sub_in = sub_ff + 2'd1;
            end
         end
         ST_ADD_MARK: if (status.mark_last) state_in = ST_OUT;
         ST_GET_SCAN: begin
            if (status.scan_end || status.limit) state_in = ST_OUT;
            else if (status.scan_dirty) state_in = ST_GET_RUN;
         end
         ST_GET_RUN: if (!status.run_more) state_in = ST_GET_DOWN;
         ST_GET_DOWN: if (!status.down_ok) state_in = ST_GET_EMIT;
         ST_GET_EMIT: begin
            if (status.rect_ok) begin
               if (!out_busy || out_take) state_in = ST_GET_SCAN;
            end else state_in = ST_GET_SCAN;
         end
         ST_OUT: if (!out_busy || out_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid && req_ready;
            cmd.grid_start = req_valid && req_ready &&
                             (req_op == OP_ADD || req_op == OP_GET);
         end
         ST_GRID: cmd.grid_start = status.grid_done && (sub_ff == 2'd0);
         ST_ADD_CLIP: begin
            cmd.clip = 1'b1;
            cmd.div_start = !status.add_empty;
         end
         ST_ADD_DIV: cmd.div_start = status.div_done && (sub_ff != 2'd3);
         ST_ADD_MARK: cmd.mark_row = 1'b1;
         ST_GET_SCAN: cmd.scan_next = !status.scan_end && !status.limit &&
                                      !status.scan_dirty;
         ST_GET_RUN: cmd.run_step = status.run_more;
         ST_GET_DOWN: cmd.down_step = status.down_ok;
         ST_GET_EMIT: begin
            if (!status.rect_ok) cmd.emit_calc = 1'b1;
            else if (!out_busy || out_take) begin
               cmd.emit_calc = 1'b1;
               cmd.load_rect = 1'b1;
            end
         end
         ST_OUT: begin
            if (!out_busy || out_take) begin
               if (op_ff == OP_GET) begin
                  cmd.load_none = !status.any_out;
               end else cmd.ack = 1'b1;
               cmd.map_clear = (op_ff == OP_CLEAR);
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      sub_ff <= sub_in;
   end
endmodule
`default_nettype wire

// File: sv/dtrt_datapath.sv
// datapath: config registers, dirty map, add clipping, get merge walk, result register
// depends on dtrt_pkg and dtrt_divider
`default_nettype none
module dtrt_datapath
   import dtrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  wire logic [1:0]  req_op,
   input  wire logic [12:0] req_area_x,
   input  wire logic [12:0] req_area_y,
   input  wire logic [13:0] req_area_w,
   input  wire logic [13:0] req_area_h,
   input  wire logic        cfg_we,
   input  wire logic [2:0]  cfg_idx,
   input  wire logic [31:0] cfg_data,
   output logic [31:0]      cfg_rdata,
   input  wire logic [2:0]  cfg_ridx,
   output logic             out_busy,
   output logic             out_take_ok,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [11:0]      rsp_rect_x,
   output logic [11:0]      rsp_rect_y,
   output logic [11:0]      rsp_rect_w,
   output logic [11:0]      rsp_rect_h,
   output logic             rsp_found,
   output logic             rsp_last
);
   localparam int NT = GRID_COLS * GRID_ROWS;
   localparam int CI_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RI_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

   // configuration
   logic [11:0] fw_ff, fh_ff;
   logic [10:0] tw_ff, th_ff;
   logic        widen_ff;
   logic [10:0] etw, eth;
   logic        size_chg;
   assign etw = (tw_ff == '0) ? 11'd1 : tw_ff;
   assign eth = (th_ff == '0) ? 11'd1 : th_ff;

   always_comb begin
      size_chg = 1'b0;
      if (cfg_we) begin
         case (cfg_idx)
            REG_FRAME_W: size_chg = fw_ff != cfg_data[11:0];
            REG_FRAME_H: size_chg = fh_ff != cfg_data[11:0];
            REG_TILE_W: size_chg = tw_ff != cfg_data[10:0];
            REG_TILE_H: size_chg = th_ff != cfg_data[10:0];
            default: size_chg = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= '0;
         fh_ff <= '0;
         tw_ff <= 11'd32;
         th_ff <= 11'd32;
         widen_ff <= 1'b0;
      end else if (cfg_we) begin
         case (cfg_idx)
            REG_FRAME_W: fw_ff <= cfg_data[11:0];
            REG_FRAME_H: fh_ff <= cfg_data[11:0];
            REG_TILE_W: tw_ff <= cfg_data[10:0];
            REG_TILE_H: th_ff <= cfg_data[10:0];
            REG_WIDEN: widen_ff <= cfg_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_ridx)
         REG_FRAME_W: cfg_rdata = {20'd0, fw_ff};
         REG_FRAME_H: cfg_rdata = {20'd0, fh_ff};
         REG_TILE_W: cfg_rdata = {21'd0, tw_ff};
         REG_TILE_H: cfg_rdata = {21'd0, th_ff};
         REG_WIDEN: cfg_rdata = {31'd0, widen_ff};
         default: cfg_rdata = '0;
      endcase
   end

   // captured item
   logic signed [14:0] x_ff, y_ff, w_ff, h_ff;
   logic signed [14:0] x_in, y_in, w_in, h_in;
   logic        empty_ff, empty_in;
   logic signed [14:0] fws, fhs, cx, cy, cw, ch;
   logic cempty;

   // shared divider
   logic        div_start, div_done;
   logic [13:0] div_num, div_q;
   logic [10:0] div_den;
   logic [1:0]  dsel_ff, dsel_in;
   logic        gsel_ff, gsel_in;
   logic [COL_W-1:0] cols_ff;
   logic [ROW_W-1:0] rows_ff;
   logic [13:0] tx_ff, ty_ff, txx_ff, tyy_ff;

   assign div_start = cmd.grid_start || cmd.div_start;

   always_comb begin
      div_num = '0;
      div_den = etw;
      if (cmd.grid_start) begin
         if (cmd.load) begin
            div_num = {2'd0, fw_ff} + {3'd0, etw} - 14'd1;
            div_den = etw;
         end else begin
            div_num = {2'd0, fh_ff} + {3'd0, eth} - 14'd1;
            div_den = eth;
         end
      end else begin
         case (dsel_in)
            2'd0: begin div_num = cx[13:0]; div_den = etw; end
            2'd1: begin div_num = y_ff[13:0]; div_den = eth; end
            2'd2: begin div_num = x_ff[13:0] + w_ff[13:0] - 14'd1; div_den = etw; end
            default: begin div_num = y_ff[13:0] + h_ff[13:0] - 14'd1; div_den = eth; end
         endcase
      end
   end

   dtrt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // clipping of the add rectangle
   always_comb begin
      fws = $signed({3'd0, fw_ff});
      fhs = $signed({3'd0, fh_ff});
      cx = x_ff; cy = y_ff; cw = w_ff; ch = h_ff;
      cempty = (w_ff <= 0) || (h_ff <= 0) || (cols_ff == '0) || (rows_ff == '0);
      if (cx < 0) begin cw = cw + cx; cx = '0; end
      if (cy < 0) begin ch = ch + cy; cy = '0; end
      if (cx + cw > fws) cw = fws - cx;
      if (cy + ch > fhs) ch = fhs - cy;
      if (cw <= 0 || ch <= 0) cempty = 1'b1;
      if (widen_ff && (cw > (fws >>> 1))) begin
         cx = '0;
         cw = fws;
      end
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; w_in = w_ff; h_in = h_ff;
      empty_in = empty_ff;
      if (cmd.load) begin
         x_in = {{2{req_area_x[12]}}, req_area_x};
         y_in = {{2{req_area_y[12]}}, req_area_y};
         w_in = {req_area_w[13], req_area_w};
         h_in = {req_area_h[13], req_area_h};
      end else if (cmd.clip) begin
         x_in = cx; y_in = cy; w_in = cw; h_in = ch;
         empty_in = cempty;
      end
   end

   assign dsel_in = cmd.clip ? 2'd0 : (cmd.div_start ? dsel_ff + 2'd1 : dsel_ff);
   assign gsel_in = cmd.load ? 1'b0 : (div_done ? ~gsel_ff : gsel_ff);

   logic grid_phase_ff;
   logic [COL_W-1:0] gsat;
   assign gsat = (div_q > 14'(GRID_COLS)) ? COL_W'(GRID_COLS) : div_q[COL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) grid_phase_ff <= 1'b0;
      else if (cmd.grid_start) grid_phase_ff <= 1'b1;
      else if (div_done && grid_phase_ff && gsel_ff) grid_phase_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; w_ff <= w_in; h_ff <= h_in;
      empty_ff <= empty_in;
      dsel_ff <= dsel_in;
      if (reset) gsel_ff <= 1'b0;
      else gsel_ff <= gsel_in;
      if (div_done && grid_phase_ff) begin
         if (!gsel_ff) cols_ff <= gsat;
         else rows_ff <= (div_q > 14'(GRID_ROWS)) ? ROW_W'(GRID_ROWS) : div_q[ROW_W-1:0];
      end
      // quotient belongs to the division that is running
      if (div_done && !grid_phase_ff) begin
         case (dsel_ff)
            2'd0: tx_ff <= div_q;
            2'd1: ty_ff <= div_q;
            2'd2: txx_ff <= div_q;
            default: tyy_ff <= div_q;
         endcase
      end
   end

   // dirty map and walk registers
   logic [NT-1:0] map_ff, map_in;
   logic [ROW_W-1:0] r_ff, r_in, mr_ff, mr_in;
   logic [COL_W-1:0] c_ff, c_in, span_ff, span_in;
   logic [ROW_W-1:0] depth_ff, depth_in;
   logic [NRES_W-1:0] n_ff, n_in;
   logic [COL_W-1:0] c_hi;
   logic [ROW_W-1:0] r_hi;
   logic [GRID_COLS-1:0] span_mask, add_mask;
   logic [GRID_COLS-1:0] row_cur, row_dn;
   logic [ROW_W:0] rdn;
   logic rows_hit;

   assign c_hi = (txx_ff >= 14'(cols_ff)) ? cols_ff - COL_W'(1) : txx_ff[COL_W-1:0];
   assign r_hi = (tyy_ff >= 14'(rows_ff)) ? rows_ff - ROW_W'(1) : tyy_ff[ROW_W-1:0];
   // top tile row may lie past the grid bound, then no row is marked
   assign rows_hit = (ty_ff <= 14'(r_hi));

   always_comb begin
      for (int i = 0; i < GRID_COLS; i++) begin
         add_mask[i] = (14'(i) >= tx_ff) && (COL_W'(i) <= c_hi);
         span_mask[i] = (COL_W'(i) >= c_ff) &&
                        ({1'b0, COL_W'(i)} < {1'b0, c_ff} + {1'b0, span_ff});
         row_cur[i] = map_ff[r_ff[RI_W-1:0] * GRID_COLS + i];
      end
   end

   assign rdn = {1'b0, r_ff} + {1'b0, depth_ff};
   always_comb begin
      for (int i = 0; i < GRID_COLS; i++) begin
         if (rdn < (ROW_W + 1)'(GRID_ROWS))
            row_dn[i] = map_ff[rdn[RI_W-1:0] * GRID_COLS + i];
         else row_dn[i] = 1'b0;
      end
   end

   logic [COL_W:0] cend;
   assign cend = {1'b0, c_ff} + {1'b0, span_ff};
   assign status.run_more = (cend < {1'b0, cols_ff}) &&
                            row_cur[cend[CI_W-1:0]];
   assign status.down_ok = (rdn < {1'b0, rows_ff}) && ((row_dn & span_mask) == span_mask);
   assign status.scan_dirty = row_cur[c_ff[CI_W-1:0]];
   assign status.scan_end = (r_ff >= rows_ff);
   assign status.limit = (n_ff == NRES_W'(MAX_RESULTS));
   assign status.any_out = (n_ff != '0);
   assign status.grid_done = div_done;
   assign status.div_done = div_done;
   assign status.add_empty = cempty;
   assign status.mark_last = (mr_ff >= r_hi) || empty_ff || !rows_hit;

   // pixel rectangle of the merged span
   logic [23:0] px, py, pw, ph;
   logic [23:0] pwc, phc;
   assign px = 24'(c_ff) * 24'(etw);
   assign py = 24'(r_ff) * 24'(eth);
   assign pw = 24'(span_ff) * 24'(etw);
   assign ph = 24'(depth_ff) * 24'(eth);
   always_comb begin
      pwc = pw;
      phc = ph;
      if (px + pw > 24'(fw_ff)) pwc = (24'(fw_ff) > px) ? 24'(fw_ff) - px : '0;
      if (py + ph > 24'(fh_ff)) phc = (24'(fh_ff) > py) ? 24'(fh_ff) - py : '0;
   end
   assign status.rect_ok = (pwc != '0) && (phc != '0);

   always_comb begin
      map_in = map_ff;
      r_in = r_ff; c_in = c_ff; span_in = span_ff; depth_in = depth_ff;
      n_in = n_ff; mr_in = mr_ff;
      if (cmd.load) begin
         r_in = '0; c_in = '0; n_in = '0;
      end
      if (cmd.clip) mr_in = '0;
      if (div_done && !grid_phase_ff && dsel_ff == 2'd3) mr_in = ty_ff[ROW_W-1:0];
      if (cmd.mark_row && !empty_ff && rows_hit) begin
         for (int i = 0; i < GRID_COLS; i++)
            if (add_mask[i]) map_in[mr_ff[RI_W-1:0] * GRID_COLS + i] = 1'b1;
         mr_in = mr_ff + ROW_W'(1);
      end
      if (cmd.scan_next) begin
         if ({1'b0, c_ff} + (COL_W + 1)'(1) >= {1'b0, cols_ff}) begin
            c_in = '0;
            r_in = r_ff + ROW_W'(1);
         end else c_in = c_ff + COL_W'(1);
      end
      if (status.scan_dirty && !cmd.scan_next && !status.scan_end && !status.limit &&
          !cmd.run_step && !cmd.down_step && !cmd.emit_calc && span_ff == '0) begin
         span_in = COL_W'(1);
         depth_in = ROW_W'(1);
      end
      if (cmd.run_step) span_in = span_ff + COL_W'(1);
      if (cmd.down_step) begin
         for (int i = 0; i < GRID_COLS; i++)
            if (span_mask[i]) map_in[rdn[RI_W-1:0] * GRID_COLS + i] = 1'b0;
         depth_in = depth_ff + ROW_W'(1);
      end
      if (cmd.emit_calc) begin
         for (int i = 0; i < GRID_COLS; i++)
            if (span_mask[i]) map_in[r_ff[RI_W-1:0] * GRID_COLS + i] = 1'b0;
         if (cend >= {1'b0, cols_ff}) begin
            c_in = '0;
            r_in = r_ff + ROW_W'(1);
         end else c_in = cend[COL_W-1:0];
         span_in = '0;
         if (cmd.load_rect) n_in = n_ff + NRES_W'(1);
      end
      if (cmd.map_clear || size_chg) map_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
         span_ff <= '0;
      end else begin
         map_ff <= map_in;
         span_ff <= span_in;
      end
      r_ff <= r_in; c_ff <= c_in; depth_ff <= depth_in;
      n_ff <= n_in; mr_ff <= mr_in;
   end

   // result register; last bit of a get is set when the walk finishes
   logic        ov_ff;
   logic [11:0] ox_ff, oy_ff, ow_ff, oh_ff;
   logic        of_ff, ol_ff;
   logic        pend_ff; // a rectangle held back until we know if it is the last
   logic        fin;
   // the held rectangle moves out only once the result register is free
   assign fin = cmd.ack || cmd.load_none ||
                (!cmd.load_rect && !cmd.ack && !cmd.load_none && pend_ff &&
                 (!ov_ff || rsp_ready) && (status.scan_end || status.limit));
   assign out_take_ok = rsp_ready;
   assign out_busy = ov_ff;

   // pending rectangle held internally
   logic [11:0] hx_ff, hy_ff, hw_ff, hh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (ov_ff && rsp_ready) ov_ff <= 1'b0;
         if (cmd.load) pend_ff <= 1'b0;
         if (cmd.load_rect) begin
            pend_ff <= 1'b1;
            if (pend_ff) ov_ff <= 1'b1;
         end else if (fin && (cmd.ack || cmd.load_none || pend_ff)) begin
            ov_ff <= 1'b1;
            pend_ff <= 1'b0;
         end
      end
      if (cmd.load_rect) begin
         hx_ff <= px[11:0]; hy_ff <= py[11:0]; hw_ff <= pwc[11:0]; hh_ff <= phc[11:0];
         if (pend_ff) begin
            ox_ff <= hx_ff; oy_ff <= hy_ff; ow_ff <= hw_ff; oh_ff <= hh_ff;
            of_ff <= 1'b1; ol_ff <= 1'b0;
         end
      end else if (fin) begin
         if (cmd.ack || cmd.load_none) begin
            ox_ff <= '0; oy_ff <= '0; ow_ff <= '0; oh_ff <= '0;
            of_ff <= 1'b0; ol_ff <= 1'b1;
         end else begin
            ox_ff <= hx_ff; oy_ff <= hy_ff; ow_ff <= hw_ff; oh_ff <= hh_ff;
            of_ff <= 1'b1; ol_ff <= 1'b1;
         end
      end
   end

   logic unused_op;
   assign unused_op = ^req_op;
   assign rsp_valid = ov_ff;
   assign rsp_rect_x = ox_ff;
   assign rsp_rect_y = oy_ff;
   assign rsp_rect_w = ow_ff;
   assign rsp_rect_h = oh_ff;
   assign rsp_found = of_ff;
   assign rsp_last = ol_ff & ~unused_op | ol_ff;
endmodule
`default_nettype wire

// File: sv/dirty_tile_rect_tracker_top.sv
// top level of the dirty tile rectangle tracker
// depends on dtrt_pkg, dtrt_ctrl, dtrt_datapath, dtrt_divider
//
// usage: req_ channel carries one item (op add, get or clear plus rectangle);
// rsp_ channel returns results, rsp_last marks the final one of an item.
// add, clear and unused ops return one acknowledgement with found low.
// get returns merged dirty rectangles, or one not-found result.
// an add runs six divisions in the shared divider and then marks its rows row
// by row; a get runs the grid divisions and then steps through the scanned
// tiles and the run/down steps. one item is in work at a time.
// a result register parts the two sides; when rsp_ready is low the walk
// waits on the held result and no new item is taken.
// reset clears the dirty map, the control state and sets registers to their
// reset values. the csr_ port is taken at any time the block is idle.
`default_nettype none
module dirty_tile_rect_tracker_top
   import dtrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [12:0] req_area_x,
   input  wire logic [12:0] req_area_y,
   input  wire logic [13:0] req_area_w,
   input  wire logic [13:0] req_area_h,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_rect_x,
   output logic [11:0]      rsp_rect_y,
   output logic [11:0]      rsp_rect_w,
   output logic [11:0]      rsp_rect_h,
   output logic             rsp_found,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cmd_type    cmd;
   status_type status;
   logic       out_busy, out_take;
   logic       cfg_we;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;

   dtrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .out_busy  (out_busy),
      .out_take  (out_take),
      .status    (status),
      .cmd       (cmd)
   );

   dtrt_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_op),
      .req_area_x  (req_area_x),
      .req_area_y  (req_area_y),
      .req_area_w  (req_area_w),
      .req_area_h  (req_area_h),
      .cfg_we      (cfg_we),
      .cfg_idx     (csr_paddr[4:2]),
      .cfg_data    (csr_pwdata),
      .cfg_rdata   (csr_prdata),
      .cfg_ridx    (csr_paddr[4:2]),
      .out_busy    (out_busy),
      .out_take_ok (out_take),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_rect_x  (rsp_rect_x),
      .rsp_rect_y  (rsp_rect_y),
      .rsp_rect_w  (rsp_rect_w),
      .rsp_rect_h  (rsp_rect_h),
      .rsp_found   (rsp_found),
      .rsp_last    (rsp_last)
   );

   // a not-found or acknowledgement result carries no rectangle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_rect_w == 12'd0)
      else $error("result without rectangle carries data");

   // no new transfer is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken under stalled result");

   // a found rectangle is never empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_rect_w != 12'd0 && rsp_rect_h != 12'd0)
      else $error("empty rectangle emitted");
endmodule
`default_nettype wire
